/* sv/apool_pkg.sv */
// Shared constants, register codes and controller/datapath interface types
// for the streaming average pooling block. No dependencies.
package apool_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_KERNEL  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int BANK_W    = $clog2(MAX_KERNEL);
  localparam int NUM_BANKS = MAX_KERNEL;
  localparam int KDIM_W    = 4;
  localparam int PW_W      = 11;
  localparam int PH_W      = 16;
  localparam int ROW_W     = 16;
  localparam int XW        = PW_W + 1;
  localparam int YW        = PH_W + 2;
  localparam int CSUM_W    = SAMPLE_BITS + BANK_W;
  localparam int SUM_W     = SAMPLE_BITS + 2 * BANK_W;
  localparam int CNT_W     = 2 * BANK_W + 1;
  localparam int DCNT_W    = $clog2(SUM_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_REGS   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_WIDTH  = 3'd0,
    REG_KERNEL_HEIGHT = 3'd1,
    REG_STRIDE_X      = 3'd2,
    REG_STRIDE_Y      = 3'd3,
    REG_PLANE_WIDTH   = 3'd4,
    REG_PLANE_HEIGHT  = 3'd5,
    REG_CEIL_MODE     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic rd_adv;
    logic sum_add;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic sum_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

/* sv/apool_ctrl.sv */
// Controller state machine for the average pooling block.
// Depends on apool_pkg for the command and status types.
module apool_ctrl import apool_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIVI,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && st.emit) state <= S_READ;
        S_READ: state <= S_SUM;
        S_SUM:  if (st.sum_last) state <= S_DIVI;
        S_DIVI: state <= S_DIV;
        S_DIV:  if (st.div_last) state <= S_OUT;
        S_OUT:  if (st.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.rd_adv   = (state == S_READ) || (state == S_SUM);
    cmd.sum_add  = (state == S_SUM);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.out_load = (state == S_OUT) && st.out_free;
  end

endmodule

/* sv/apool_dp.sv */
// Datapath of the average pooling block: registers, raster trackers, banked
// line store, column adder, serial divider and result register. Uses apool_pkg.
module apool_dp import apool_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  cmd_t                          cmd,
  output status_t                       st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic [COL_W-1:0]              out_col,
  output logic [ROW_W-1:0]              out_row,
  output logic                          plane_done
);

  logic [KDIM_W-1:0] reg_kw, reg_kh, reg_sx, reg_sy;
  logic [PW_W-1:0]   reg_w;
  logic [PH_W-1:0]   reg_h;
  logic              reg_ceil;
  logic              cfg_hit;

  assign cfg_hit = cfg_valid && (cfg_index < CFG_IDX_W'(CFG_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_kw   <= KDIM_W'(2);
      reg_kh   <= KDIM_W'(2);
      reg_sx   <= KDIM_W'(2);
      reg_sy   <= KDIM_W'(2);
      reg_w    <= PW_W'(1024);
      reg_h    <= PH_W'(1024);
      reg_ceil <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL_WIDTH:  reg_kw   <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_HEIGHT: reg_kh   <= cfg_data[KDIM_W-1:0];
        REG_STRIDE_X:      reg_sx   <= cfg_data[KDIM_W-1:0];
        REG_STRIDE_Y:      reg_sy   <= cfg_data[KDIM_W-1:0];
        REG_PLANE_WIDTH:   reg_w    <= cfg_data[PW_W-1:0];
        REG_PLANE_HEIGHT:  reg_h    <= cfg_data[PH_W-1:0];
        REG_CEIL_MODE:     reg_ceil <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) settings
  logic [KDIM_W-1:0] kw, kh, sx, sy;
  logic [PW_W-1:0]   w;
  logic [PH_W-1:0]   h;

  assign kw = (reg_kw == '0) ? KDIM_W'(1) :
              (reg_kw > KDIM_W'(MAX_KERNEL)) ? KDIM_W'(MAX_KERNEL) : reg_kw;
  assign kh = (reg_kh == '0) ? KDIM_W'(1) :
              (reg_kh > KDIM_W'(MAX_KERNEL)) ? KDIM_W'(MAX_KERNEL) : reg_kh;
  assign sx = (reg_sx == '0) ? KDIM_W'(1) : reg_sx;
  assign sy = (reg_sy == '0) ? KDIM_W'(1) : reg_sy;
  assign w  = (reg_w == '0) ? PW_W'(1) :
              (reg_w > PW_W'(MAX_WIDTH)) ? PW_W'(MAX_WIDTH) : reg_w;
  assign h  = (reg_h == '0) ? PH_W'(1) : reg_h;

  // Raster position and current window trackers
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] xx;
  logic [ROW_W-1:0] yy;
  logic [PW_W-1:0]  xs;
  logic [YW-2:0]    ys;

  logic [XW-1:0] c_e, xs_e, kw_e, sx_e, w_e;
  logic [YW-1:0] r_e, ys_e, kh_e, sy_e, h_e;
  logic x_valid, x_corner, x_more, y_valid, y_corner, y_more;
  logic last_col, last_row;

  assign c_e  = XW'(col_pos);
  assign xs_e = XW'(xs);
  assign kw_e = XW'(kw);
  assign sx_e = XW'(sx);
  assign w_e  = XW'(w);
  assign r_e  = YW'(row_pos);
  assign ys_e = YW'(ys);
  assign kh_e = YW'(kh);
  assign sy_e = YW'(sy);
  assign h_e  = YW'(h);

  assign last_col = (c_e + XW'(1) >= w_e);
  assign last_row = (r_e + YW'(1) >= h_e);

  // A window is live if the plane fits the kernel and its start is in range;
  // ceil mode keeps one clipped window past the floor count.
  assign x_valid = (w_e >= kw_e) && ((xs == '0) || ((xs_e < w_e) &&
                   (reg_ceil ? (xs_e + kw_e < w_e + sx_e) : (xs_e + kw_e <= w_e))));
  assign x_corner = x_valid && ((xs_e + kw_e - XW'(1) == c_e) ||
                    (last_col && (xs_e + kw_e > w_e)));
  assign x_more = (xs_e + sx_e < w_e) &&
                  (reg_ceil ? (xs_e + kw_e < w_e) : (xs_e + sx_e + kw_e <= w_e));

  assign y_valid = (h_e >= kh_e) && ((ys == '0) || ((ys_e < h_e) &&
                   (reg_ceil ? (ys_e + kh_e < h_e + sy_e) : (ys_e + kh_e <= h_e))));
  assign y_corner = y_valid && ((ys_e + kh_e - YW'(1) == r_e) ||
                    (last_row && (ys_e + kh_e > h_e)));
  assign y_more = (ys_e + sy_e < h_e) &&
                  (reg_ceil ? (ys_e + kh_e < h_e) : (ys_e + sy_e + kh_e <= h_e));

  assign st.emit = x_corner && y_corner;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_pos <= '0;
      row_pos <= '0;
      xx      <= '0;
      yy      <= '0;
      xs      <= '0;
      ys      <= '0;
    end else if (cmd.accept) begin
      if (last_col) begin
        col_pos <= '0;
        xx      <= '0;
        xs      <= '0;
        if (last_row) begin
          row_pos <= '0;
          yy      <= '0;
          ys      <= '0;
        end else begin
          row_pos <= row_pos + ROW_W'(1);
          if (y_corner) begin
            yy <= yy + ROW_W'(1);
            ys <= (YW-1)'(ys_e + sy_e);
          end
        end
      end else begin
        col_pos <= col_pos + COL_W'(1);
        if (x_corner) begin
          xx <= xx + COL_W'(1);
          xs <= PW_W'(xs_e + sx_e);
        end
      end
    end
  end

  // Window snapshot taken with the request
  logic [BANK_W-1:0] cap_bank;
  logic [KDIM_W-1:0] rh, rem;
  logic [CNT_W-1:0]  cnt;
  logic [COL_W-1:0]  rd_col;
  logic [KDIM_W-1:0] cw_now, rh_now;
  logic [COL_W-1:0]  win_col;
  logic [ROW_W-1:0]  win_row;
  logic              win_last;

  assign cw_now = KDIM_W'(c_e - xs_e + XW'(1));
  assign rh_now = KDIM_W'(r_e - ys_e + YW'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cap_bank <= row_pos[BANK_W-1:0];
      rh       <= rh_now;
      rem      <= cw_now;
      cnt      <= CNT_W'(CNT_W'(rh_now) * CNT_W'(cw_now));
      win_col  <= xx;
      win_row  <= yy;
      win_last <= !x_more && !y_more;
      rd_col   <= xs[COL_W-1:0];
    end else begin
      if (cmd.rd_adv) rd_col <= rd_col + COL_W'(1);
      if (cmd.sum_add) rem <= rem - KDIM_W'(1);
    end
  end

  assign st.sum_last = (rem == KDIM_W'(1));

  // Line store: one bank per row modulo the kernel limit, all read per column
  logic signed [SAMPLE_BITS-1:0] bank_mem [NUM_BANKS][MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rd_data [NUM_BANKS];

  always_ff @(posedge clk) begin
    if (cmd.accept) bank_mem[row_pos[BANK_W-1:0]][col_pos] <= sample;
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_data[b] <= bank_mem[b][rd_col];
    end
  end

  logic signed [CSUM_W-1:0] colsum;

  always_comb begin
    logic [BANK_W-1:0] d;
    colsum = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      d = cap_bank - BANK_W'(b);
      if ({1'b0, d} < rh) colsum = colsum + CSUM_W'(rd_data[b]);
    end
  end

  logic signed [SUM_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.accept) acc <= '0;
    else if (cmd.sum_add) acc <= acc + SUM_W'(colsum);
  end

  // Restoring divider on the magnitude, one quotient bit per cycle
  logic              neg;
  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  drem;
  logic [DCNT_W-1:0] div_cnt;
  logic [CNT_W:0]    trial;
  logic [SUM_W-1:0]  quot;

  assign trial = {drem, dq[SUM_W-1]};
  assign quot  = neg ? (~dq + SUM_W'(1)) : dq;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg     <= acc[SUM_W-1];
      dq      <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
      drem    <= '0;
      div_cnt <= DCNT_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCNT_W'(1);
      if (trial >= {1'b0, cnt}) begin
        drem <= CNT_W'(trial - {1'b0, cnt});
        dq   <= {dq[SUM_W-2:0], 1'b1};
      end else begin
        drem <= trial[CNT_W-1:0];
        dq   <= {dq[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign st.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the whole result steady until the receiver takes it
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average    <= quot[SAMPLE_BITS-1:0];
      out_col    <= win_col;
      out_row    <= win_row;
      plane_done <= win_last;
    end
  end

  assign st.out_free = !out_valid || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an unsent result");

  a_sum_count: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_add |-> (rem != '0))
    else $error("column sum ran past the window width");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (cnt != '0 && cnt <= CNT_W'(MAX_KERNEL * MAX_KERNEL)))
    else $error("window sample count out of range");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (c_e < w_e))
    else $error("column position beyond plane width");

endmodule

/* sv/average_pool_2d_forward.sv */
// Streaming 2-D average pooling: top level joining controller and datapath.
// Depends on apool_pkg, apool_ctrl and apool_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready/sample) takes one signed Q8.8 sample per
//    request, raster order; planes follow back to back as the counters wrap.
//  - Output channel (out_valid/out_ready) delivers average, out_col, out_row
//    and plane_done (set on the plane's last window) for each window whose
//    bottom-right corner the sample completes.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//    a write to a defined index also restarts the plane at row 0, column 0.
//    Write only while no request is in flight.
//  - A sample that closes no window is taken straight from the idle state. One that
//    closes a window holds off the input while the line store gives one column of up to
//    8 rows per cycle across the window's width W in columns (1..8), then a 22-step
//    serial divider produces the truncated mean.
//  - The finished result sits in an output register; if the receiver stalls,
//    the block keeps taking samples and holds only the next window's result
//    until the register frees.
//  - Reset (rst, synchronous) restores the default registers (2x2 kernel,
//    stride 2, 1024x1024 plane, floor mode) and clears positions; the line
//    store is not cleared and needs no clearing pass.
module average_pool_2d_forward import apool_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic [COL_W-1:0]              out_col,
  output logic [ROW_W-1:0]              out_row,
  output logic                          plane_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t st;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  apool_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  apool_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .average    (average),
    .out_col    (out_col),
    .out_row    (out_row),
    .plane_done (plane_done)
  );

endmodule

/* tb/average_pool_2d_forward_tb.sv */
// Self-checking bench for the streaming 2-D average pooling block.
// Depends on apool_pkg and the average_pool_2d_forward top level.
module average_pool_2d_forward_tb;
  import apool_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] avg;
    logic [9:0]         col;
    logic [15:0]        row;
    logic               last;
  } pool_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] average;
  logic [9:0] out_col;
  logic [15:0] out_row;
  logic plane_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  average_pool_2d_forward i_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block's registers and position.
  int unsigned kw_reg, kh_reg, sx_reg, sy_reg, pw_reg, ph_reg, ceil_reg;
  int unsigned col_at, row_at;
  int line_buf [MAX_KERNEL][MAX_WIDTH];

  pool_res_t pending_windows[$];
  int  errors = 0;
  longint cycles = 0;
  bit  idle_free = 0;    // long stretch with no idling at all
  bit  stall_long = 0;   // receiver holds off
  int  sent_items = 0;

  function automatic int unsigned windows_along(int unsigned size, k, s);
    int unsigned n;
    if (size < k) return 0;
    if (ceil_reg) begin
      n = (size - k + s - 1) / s + 1;
      if ((n - 1) * s >= size) n--;
    end else begin
      n = (size - k) / s + 1;
    end
    return n;
  endfunction

  function automatic int window_end(int unsigned p, size, k, s, n);
    if (n == 0 || p >= size) return -1;
    if (p + 1 >= k && (p + 1 - k) % s == 0 && (p + 1 - k) / s < n)
      return (p + 1 - k) / s;
    if (p == size - 1 && (n - 1) * s + k > size) return n - 1;
    return -1;
  endfunction

  // Store the sample, queue the window average it completes, advance.
  function automatic void pool_sample(logic signed [15:0] v);
    int unsigned kw, kh, sx, sy, w, h, nw, nh, xs, ys, cnt;
    int xx, yy;
    longint acc;
    pool_res_t r;
    kw = (kw_reg < 1) ? 1 : (kw_reg > MAX_KERNEL ? MAX_KERNEL : kw_reg);
    kh = (kh_reg < 1) ? 1 : (kh_reg > MAX_KERNEL ? MAX_KERNEL : kh_reg);
    sx = sx_reg ? sx_reg : 1;
    sy = sy_reg ? sy_reg : 1;
    w = (pw_reg < 1) ? 1 : (pw_reg > MAX_WIDTH ? MAX_WIDTH : pw_reg);
    h = ph_reg ? ph_reg : 1;
    nw = windows_along(w, kw, sx);
    nh = windows_along(h, kh, sy);
    line_buf[row_at % MAX_KERNEL][col_at] = v;
    xx = window_end(col_at, w, kw, sx, nw);
    yy = window_end(row_at, h, kh, sy, nh);
    if (xx >= 0 && yy >= 0) begin
      xs = xx * sx;
      ys = yy * sy;
      cnt = (row_at - ys + 1) * (col_at - xs + 1);
      acc = 0;
      for (int unsigned y = ys; y <= row_at; y++)
        for (int unsigned x = xs; x <= col_at; x++)
          acc += line_buf[y % MAX_KERNEL][x];
      r.avg = 16'(acc / longint'(cnt));
      r.col = 10'(xx);
      r.row = 16'(yy);
      r.last = (xx == nw - 1) && (yy == nh - 1);
      pending_windows.push_back(r);
    end
    if (col_at + 1 >= w) begin
      col_at = 0;
      row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
  endfunction

  // Drop valid only while idling, so back-to-back requests keep it high.
  task automatic idle_gap();
    while (!idle_free && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_sample(logic signed [15:0] v);
    idle_gap();
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
    pool_sample(v);
    sent_items++;
  endtask

  // Wait for the pipeline to drain, then write one register.
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KERNEL_WIDTH:  kw_reg = val & 4'hF;
      REG_KERNEL_HEIGHT: kh_reg = val & 4'hF;
      REG_STRIDE_X:      sx_reg = val & 4'hF;
      REG_STRIDE_Y:      sy_reg = val & 4'hF;
      REG_PLANE_WIDTH:   pw_reg = val & 11'h7FF;
      REG_PLANE_HEIGHT:  ph_reg = val & 16'hFFFF;
      REG_CEIL_MODE:     ceil_reg = val & 1;
      default: ;
    endcase
    col_at = 0;
    row_at = 0;
  endtask

  task automatic set_shape(int unsigned kw, kh, sx, sy, pw, ph, cm);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_STRIDE_X, sx);
    write_reg(REG_STRIDE_Y, sy);
    write_reg(REG_PLANE_WIDTH, pw);
    write_reg(REG_PLANE_HEIGHT, ph);
    write_reg(REG_CEIL_MODE, cm);
  endtask

  // Directed table: 4x4 plane, 2x2 kernel, stride 2, floor mode. The
  // expected average is typed in on window corners where it is obvious.
  typedef struct {
    logic signed [15:0] v;
    bit                 has_exp;
    logic signed [15:0] exp_avg;
  } dir_row_t;

  dir_row_t dir_rows[16] = '{
    '{16'sh7FFF, 0, 0}, '{16'sh7FFF, 0, 0}, '{-16'sd32768, 0, 0}, '{-16'sd32768, 0, 0},
    '{16'sh7FFF, 0, 0}, '{16'sh7FFF, 1, 16'sh7FFF},
    '{-16'sd32768, 0, 0}, '{-16'sd32768, 1, -16'sd32768},
    '{16'sd1, 0, 0}, '{16'sd2, 0, 0}, '{-16'sd1, 0, 0}, '{16'sd0, 0, 0},
    '{16'sd0, 0, 0}, '{16'sd0, 0, 0}, '{-16'sd1, 0, 0}, '{-16'sd1, 0, 0}
  };

  // Sender: directed table, then random planes under several shapes.
  initial begin : stimulus
    int unsigned kw, kh, sx, sy, pw, ph, cm, n;
    kw_reg = 2; kh_reg = 2; sx_reg = 2; sy_reg = 2;
    pw_reg = 1024; ph_reg = 1024; ceil_reg = 0;
    col_at = 0; row_at = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_shape(2, 2, 2, 2, 4, 4, 0);
    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].v);
      if (dir_rows[i].has_exp && pending_windows[$].avg !== dir_rows[i].exp_avg) begin
        $error("average: table expects %0d, predictor gives %0d",
               dir_rows[i].exp_avg, pending_windows[$].avg);
        errors++;
      end
    end
    // Extremes: kernel 0 and 15 clamp, zero strides and sizes, ceil clipping.
    set_shape(0, 15, 0, 15, 3, 2, 1);
    repeat (8) send_sample(16'($urandom));
    set_shape(8, 8, 8, 8, 9, 9, 1);
    while (sent_items < 16 + 8 + 81) send_sample(16'($urandom));
    set_shape(3, 3, 1, 1, 2, 2, 0);  // plane smaller than kernel
    repeat (4) send_sample(16'($urandom));
    set_shape(1, 1, 1, 1, 0, 0, 0);
    repeat (2) send_sample(16'h8000);
    // Random shapes; keep planes small so windows show up often.
    idle_free = 1;
    while (sent_items < 540) begin
      kw = $urandom_range(8, 1); kh = $urandom_range(8, 1);
      sx = $urandom_range(8, 1); sy = $urandom_range(8, 1);
      pw = $urandom_range(12, 1); ph = $urandom_range(12, 1);
      cm = $urandom_range(1);
      // Full-width rows: single-row kernel so a partial plane still pools.
      if ($urandom_range(9) == 0) begin
        pw = 1024;
        kh = 1;
      end
      set_shape(kw, kh, sx, sy, pw, ph, cm);
      if (sent_items > 250) idle_free = 0;
      n = (pw == 1024) ? 2048 + 8 : pw * ph * $urandom_range(2, 1);
      if (n > 560 - sent_items) n = 560 - sent_items;
      if (sent_items > 150) stall_long = 1;
      repeat (n) send_sample(16'($urandom));
      if (pw == 1024) set_shape(2, 2, 2, 2, 4, 4, 0);
    end
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("average_pool_2d_forward: match");
    else $display("average_pool_2d_forward: mismatch");
    $finish;
  end

  // Receiver: random stalls, one long hold-off counted here.
  initial begin : sink
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (stall_long && held < 600) begin
        held++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 30);
      end
    end
  end

  // Compare each delivered window with the oldest queued prediction.
  always @(posedge clk) begin
    pool_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_windows.size() == 0) begin
        $error("unexpected window avg=%0d col=%0d row=%0d", average, out_col, out_row);
        errors++;
      end else begin
        e = pending_windows.pop_front();
        if (average !== e.avg) begin
          $error("average: expected %0d, got %0d", e.avg, average); errors++;
        end
        if (out_col !== e.col) begin
          $error("out_col: expected %0d, got %0d", e.col, out_col); errors++;
        end
        if (out_row !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, out_row); errors++;
        end
        if (plane_done !== e.last) begin
          $error("plane_done: expected %0d, got %0d", e.last, plane_done); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("average_pool_2d_forward: mismatch");
      $finish;
    end
  end
endmodule
